// ===== rtl/gpio_pkg.sv =====
// Package for the GPIO port with lock: request and response words, register
// index codes, lock sequence states and pin field helpers. No dependencies.
package gpio_pkg;

   localparam int PIN_COUNT = 16;
   localparam logic [15:0] PIN_MASK = 16'hFFFF >> (16 - PIN_COUNT);

   typedef enum logic {
      OP_READ  = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   typedef enum logic [3:0] {
      REG_MODE    = 4'd0,
      REG_OTYPE   = 4'd1,
      REG_SPEED   = 4'd2,
      REG_PULL    = 4'd3,
      REG_IDR     = 4'd4,
      REG_ODR     = 4'd5,
      REG_BSRR    = 4'd6,
      REG_LOCK    = 4'd7,
      REG_AF_LOW  = 4'd8,
      REG_AF_HIGH = 4'd9
   } reg_index_type;

   typedef enum logic [1:0] {
      LOCK_WAIT_FIRST = 2'd0,
      LOCK_WAIT_PINS  = 2'd1,
      LOCK_WAIT_KEY   = 2'd2,
      LOCK_WAIT_READ  = 2'd3
   } lock_step_type;

   typedef struct packed {
      logic        op;
      logic [3:0]  reg_index;
      logic [31:0] write_data;
      logic [15:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic [15:0] pin_drive;
   } rsp_type;

   // Widens a pin mask to a mask over 2-bit per-pin fields.
   function automatic logic [31:0] spread2(input logic [15:0] pins);
      logic [31:0] m;
      m = '0;
      for (int k = 0; k < 16; k++) begin
         m[2*k +: 2] = {2{pins[k]}};
      end
      return m;
   endfunction

   // Widens eight pins to a mask over 4-bit per-pin fields.
   function automatic logic [31:0] spread4(input logic [7:0] pins);
      logic [31:0] m;
      m = '0;
      for (int k = 0; k < 8; k++) begin
         m[4*k +: 4] = {4{pins[k]}};
      end
      return m;
   endfunction

endpackage

// ===== rtl/gpio_port_with_lock.sv =====
// Top level of the GPIO port with lock: register file, lock key sequence and
// the response register. Depends on gpio_pkg.
//
// Use: each request word is one bus access (read or write of one port
// register) together with the sampled pin levels. Each accepted request gives
// exactly one response word: the read data (zero on writes) and the output
// data driven to the pins after the access.
// Both channels use valid and stall; a word moves at a clock edge with valid
// high and stall low. The register update and the response are computed in
// the cycle of acceptance and captured in the response register, so a new
// request is accepted every cycle while the receiver does not stall.
// The response register is the only buffer: while it holds a word and the
// receiver stalls, req_stall is raised and the held word does not change.
// Once the receiver takes the word, a new request can enter in the same cycle.
// A synchronous reset clears all port registers, the lock and the key
// sequence, and empties the response register. A completed lock sequence
// freezes the configuration fields of the chosen pins until the next reset.
module gpio_port_with_lock
   import gpio_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

   logic [31:0] mode_ff, mode_in;
   logic [15:0] otype_ff, otype_in;
   logic [31:0] speed_ff, speed_in;
   logic [31:0] pull_ff, pull_in;
   logic [31:0] af_low_ff, af_low_in;
   logic [31:0] af_high_ff, af_high_in;
   logic [15:0] out_data_ff, out_data_in;
   logic [15:0] lock_pins_ff, lock_pins_in;
   logic        lock_key_ff, lock_key_in;
   lock_step_type lock_step_ff, lock_step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic          req_accept;
   logic          is_write;
   reg_index_type idx;
   logic [15:0]   wr_pins;
   logic [15:0]   new_pins;
   logic          new_key;
   logic          same_pins;

   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;
   assign is_write   = (req_word.op == OP_WRITE);
   assign idx        = reg_index_type'(req_word.reg_index);
   assign wr_pins    = PIN_MASK & ~(lock_key_ff ? lock_pins_ff : 16'h0000);
   assign new_pins   = req_word.write_data[15:0] & PIN_MASK;
   assign new_key    = req_word.write_data[16];
   assign same_pins  = (new_pins == lock_pins_ff);

   // Lock key sequence: next state.
   always_comb begin
      lock_step_in = lock_step_ff;
      lock_pins_in = lock_pins_ff;
      lock_key_in  = lock_key_ff;
      if (req_accept && idx == REG_LOCK) begin
         if (is_write) begin
            if (lock_key_ff) begin
               lock_step_in = LOCK_WAIT_FIRST;
            end else begin
               lock_pins_in = new_pins;
               case (lock_step_ff)
                  LOCK_WAIT_PINS: begin
                     lock_step_in = (!new_key && same_pins) ? LOCK_WAIT_KEY :
                                    (new_key ? LOCK_WAIT_PINS : LOCK_WAIT_FIRST);
                  end
                  LOCK_WAIT_KEY: begin
                     lock_step_in = (new_key && same_pins) ? LOCK_WAIT_READ :
                                    (new_key ? LOCK_WAIT_PINS : LOCK_WAIT_FIRST);
                  end
                  default: begin
                     lock_step_in = new_key ? LOCK_WAIT_PINS : LOCK_WAIT_FIRST;
                  end
               endcase
            end
         end else begin
            if (!lock_key_ff && lock_step_ff == LOCK_WAIT_READ) begin
               lock_key_in = 1'b1;
            end
            lock_step_in = LOCK_WAIT_FIRST;
         end
      end
   end

   // Register writes and the response word.
   always_comb begin
      mode_in      = mode_ff;
      otype_in     = otype_ff;
      speed_in     = speed_ff;
      pull_in      = pull_ff;
      af_low_in    = af_low_ff;
      af_high_in   = af_high_ff;
      out_data_in  = out_data_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (req_accept) begin
         rsp_in.read_data = '0;
         if (is_write) begin
            case (idx)
               REG_MODE: begin
                  mode_in = (mode_ff & ~spread2(wr_pins))
                          | (req_word.write_data & spread2(wr_pins));
               end
               REG_OTYPE: begin
                  otype_in = (otype_ff & ~wr_pins) | (req_word.write_data[15:0] & wr_pins);
               end
               REG_SPEED: begin
                  speed_in = (speed_ff & ~spread2(wr_pins))
                           | (req_word.write_data & spread2(wr_pins));
               end
               REG_PULL: begin
                  pull_in = (pull_ff & ~spread2(wr_pins))
                          | (req_word.write_data & spread2(wr_pins));
               end
               REG_ODR: begin
                  out_data_in = new_pins;
               end
               REG_BSRR: begin
                  out_data_in = ((out_data_ff & ~(req_word.write_data[31:16] & PIN_MASK))
                                | new_pins) & PIN_MASK;
               end
               REG_AF_LOW: begin
                  af_low_in = (af_low_ff & ~spread4(wr_pins[7:0]))
                            | (req_word.write_data & spread4(wr_pins[7:0]));
               end
               REG_AF_HIGH: begin
                  af_high_in = (af_high_ff & ~spread4(wr_pins[15:8]))
                             | (req_word.write_data & spread4(wr_pins[15:8]));
               end
               default: begin
               end
            endcase
         end else begin
            case (idx)
               REG_MODE:    rsp_in.read_data = mode_ff;
               REG_OTYPE:   rsp_in.read_data = {16'h0000, otype_ff};
               REG_SPEED:   rsp_in.read_data = speed_ff;
               REG_PULL:    rsp_in.read_data = pull_ff;
               REG_IDR:     rsp_in.read_data = {16'h0000, req_word.pin_levels & PIN_MASK};
               REG_ODR:     rsp_in.read_data = {16'h0000, out_data_ff};
               REG_LOCK:    rsp_in.read_data = {15'h0000, lock_key_in, lock_pins_ff};
               REG_AF_LOW:  rsp_in.read_data = af_low_ff;
               REG_AF_HIGH: rsp_in.read_data = af_high_ff;
               default:     rsp_in.read_data = '0;
            endcase
         end
         rsp_in.pin_drive = out_data_in;
         rsp_valid_in     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= '0;
         otype_ff     <= '0;
         speed_ff     <= '0;
         pull_ff      <= '0;
         af_low_ff    <= '0;
         af_high_ff   <= '0;
         out_data_ff  <= '0;
         lock_pins_ff <= '0;
         lock_key_ff  <= 1'b0;
         lock_step_ff <= LOCK_WAIT_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         otype_ff     <= otype_in;
         speed_ff     <= speed_in;
         pull_ff      <= pull_in;
         af_low_ff    <= af_low_in;
         af_high_ff   <= af_high_in;
         out_data_ff  <= out_data_in;
         lock_pins_ff <= lock_pins_in;
         lock_key_ff  <= lock_key_in;
         lock_step_ff <= lock_step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   // The lock, once set, holds until reset.
   a_lock_holds: assert property (@(posedge clock) disable iff (reset)
      lock_key_ff |=> lock_key_ff)
      else $error("lock key bit cleared without reset");

   // The lock is set only by a lock read at the end of the key sequence.
   a_lock_set: assert property (@(posedge clock) disable iff (reset)
      (!lock_key_ff && lock_key_in) |-> (req_accept && !is_write && idx == REG_LOCK
                                         && lock_step_ff == LOCK_WAIT_READ))
      else $error("lock set outside the key sequence");

   // Locked pins keep their mode fields.
   a_mode_frozen: assert property (@(posedge clock) disable iff (reset)
      lock_key_ff |=> ((mode_ff & spread2($past(lock_pins_ff)))
                       == ($past(mode_ff) & spread2($past(lock_pins_ff)))))
      else $error("mode field of a locked pin changed");

   // A taken response with no new request leaves the response register empty.
   a_rsp_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_stall && !req_accept) |=> !rsp_valid_ff)
      else $error("response repeated");

   // An accepted request always produces a response word.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted request gave no response");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for gpio_port_with_lock. It uses gpio_pkg and the RTL.
// Each accepted access word is run through a port model that predicts the response.
// The monitor checks every response word against those predictions, in order.
module testbench;
   import gpio_pkg::*;

   localparam int HOLD_CYCLES = 64;
   localparam int REPORT_LIMIT = 10;
   localparam int KEY_BIT = 16;
   localparam logic [3:0] REG_UNMAPPED_LOW = 4'd10;
   localparam logic [3:0] REG_UNMAPPED_HIGH = 4'd15;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   rsp_type rsp_word;

   req_type pending_accesses[$];
   rsp_type predicted_words[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int check_failures = 0;
   bit hold_kick = 1'b0;
   bit hold_seen = 1'b0;
   int hold_left = 0;

   logic [31:0] port_mode = '0;
   logic [15:0] port_otype = '0;
   logic [31:0] port_speed = '0;
   logic [31:0] port_pull = '0;
   logic [31:0] port_af_low = '0;
   logic [31:0] port_af_high = '0;
   logic [15:0] port_odr = '0;
   logic [15:0] lock_pins = '0;
   logic lock_key = 1'b0;
   lock_step_type lock_step = LOCK_WAIT_FIRST;

   gpio_port_with_lock u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [31:0] pin_fields(input int width, input int first,
                                              input logic [15:0] pins);
      logic [31:0] m;
      m = '0;
      for (int k = 0; k * width < 32; k++) begin
         if (first + k < PIN_COUNT && pins[first + k]) begin
            for (int b = 0; b < width; b++) begin
               m[k * width + b] = 1'b1;
            end
         end
      end
      return m;
   endfunction

   function automatic logic [31:0] cfg_after_write(input logic [31:0] old, input int width,
                                                   input int first, input logic [31:0] data);
      logic [31:0] writable;
      writable = pin_fields(width, first, 16'hFFFF);
      if (lock_key) begin
         writable &= ~pin_fields(width, first, lock_pins);
      end
      return (old & ~writable) | (data & writable);
   endfunction

   function automatic rsp_type apply_access(input req_type w);
      rsp_type r;
      logic [31:0] wide;
      logic [15:0] pins;
      logic key;
      r = '0;
      if (w.op == OP_WRITE) begin
         case (w.reg_index)
            REG_MODE: port_mode = cfg_after_write(port_mode, 2, 0, w.write_data);
            REG_OTYPE: begin
               wide = cfg_after_write({16'b0, port_otype}, 1, 0, w.write_data);
               port_otype = wide[15:0];
            end
            REG_SPEED: port_speed = cfg_after_write(port_speed, 2, 0, w.write_data);
            REG_PULL: port_pull = cfg_after_write(port_pull, 2, 0, w.write_data);
            REG_ODR: port_odr = w.write_data[15:0] & PIN_MASK;
            REG_BSRR: begin
               port_odr = (port_odr & ~(w.write_data[31:16] & PIN_MASK))
                          | (w.write_data[15:0] & PIN_MASK);
            end
            REG_LOCK: begin
               key = w.write_data[KEY_BIT];
               pins = w.write_data[15:0] & PIN_MASK;
               if (lock_key) begin
                  lock_step = LOCK_WAIT_FIRST;
               end else begin
                  if (lock_step == LOCK_WAIT_PINS && !key && pins == lock_pins) begin
                     lock_step = LOCK_WAIT_KEY;
                  end else if (lock_step == LOCK_WAIT_KEY && key && pins == lock_pins) begin
                     lock_step = LOCK_WAIT_READ;
                  end else begin
                     lock_step = key ? LOCK_WAIT_PINS : LOCK_WAIT_FIRST;
                  end
                  lock_pins = pins;
               end
            end
            REG_AF_LOW: port_af_low = cfg_after_write(port_af_low, 4, 0, w.write_data);
            REG_AF_HIGH: port_af_high = cfg_after_write(port_af_high, 4, 8, w.write_data);
            default: ;
         endcase
      end else begin
         case (w.reg_index)
            REG_MODE: r.read_data = port_mode;
            REG_OTYPE: r.read_data = {16'b0, port_otype};
            REG_SPEED: r.read_data = port_speed;
            REG_PULL: r.read_data = port_pull;
            REG_IDR: r.read_data = {16'b0, w.pin_levels & PIN_MASK};
            REG_ODR: r.read_data = {16'b0, port_odr};
            REG_LOCK: begin
               if (!lock_key && lock_step == LOCK_WAIT_READ) begin
                  lock_key = 1'b1;
               end
               lock_step = LOCK_WAIT_FIRST;
               r.read_data = {15'b0, lock_key, lock_pins};
            end
            REG_AF_LOW: r.read_data = port_af_low;
            REG_AF_HIGH: r.read_data = port_af_high;
            default: r.read_data = '0;
         endcase
      end
      r.pin_drive = port_odr;
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predicted_words.push_back(apply_access(req_word));
         end
         if (!req_valid || !req_stall) begin
            if (pending_accesses.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_word <= pending_accesses.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (hold_kick != hold_seen) begin
         hold_seen <= hold_kick;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_words.size() == 0) begin
            check_failures++;
            if (check_failures <= REPORT_LIMIT) begin
               $display("Unexpected response word: read_data %h pin_drive %h",
                        rsp_word.read_data, rsp_word.pin_drive);
            end
         end else begin
            want = predicted_words.pop_front();
            if (rsp_word.read_data !== want.read_data
                || rsp_word.pin_drive !== want.pin_drive) begin
               check_failures++;
               if (check_failures <= REPORT_LIMIT) begin
                  $display("Mismatch: read_data exp %h got %h, pin_drive exp %h got %h",
                           want.read_data, rsp_word.read_data,
                           want.pin_drive, rsp_word.pin_drive);
               end
            end
         end
      end
   end

   task automatic queue_access(input logic op, input logic [3:0] idx,
                               input logic [31:0] data, input logic [15:0] levels);
      req_type w;
      w.op = op;
      w.reg_index = idx;
      w.write_data = data;
      w.pin_levels = levels;
      pending_accesses.push_back(w);
   endtask

   function automatic logic [31:0] lock_data(input logic key, input logic [15:0] pins);
      logic [31:0] d;
      d = $urandom;
      d[KEY_BIT] = key;
      d[15:0] = pins;
      return d;
   endfunction

   task automatic queue_random_access();
      logic [3:0] idx;
      if ($urandom_range(99) < 8) begin
         idx = 4'($urandom_range(REG_UNMAPPED_HIGH, REG_UNMAPPED_LOW));
      end else begin
         idx = 4'($urandom_range(REG_AF_HIGH, REG_MODE));
      end
      queue_access(1'($urandom_range(1)), idx, $urandom, 16'($urandom));
   endtask

   task automatic queue_lock_attempt(input bit complete);
      logic [15:0] pins;
      logic [15:0] bad_pins;
      logic [3:0] idx;
      logic key;
      int break_at;
      pins = 16'($urandom);
      break_at = complete ? 4 : $urandom_range(3, 1);
      for (int s = 0; s < 4; s++) begin
         if ($urandom_range(99) < 30) begin
            idx = 4'($urandom_range(REG_LOCK, REG_MODE));
            if (idx >= REG_LOCK) begin
               idx++;
            end
            queue_access(1'($urandom_range(1)), idx, $urandom, 16'($urandom));
         end
         key = (s != 1);
         if (s == break_at) begin
            bad_pins = pins ^ (16'h1 << $urandom_range(15));
            case ($urandom_range(2, s == 3 ? 1 : 0))
               0: queue_access(OP_READ, REG_LOCK, $urandom, 16'($urandom));
               1: queue_access(OP_WRITE, REG_LOCK, lock_data(!key, pins), 16'($urandom));
               default: queue_access(OP_WRITE, REG_LOCK, lock_data(key, bad_pins),
                                     16'($urandom));
            endcase
            return;
         end
         if (s == 3) begin
            queue_access(OP_READ, REG_LOCK, $urandom, 16'($urandom));
         end else begin
            queue_access(OP_WRITE, REG_LOCK, lock_data(key, pins), 16'($urandom));
         end
      end
   endtask

   task automatic queue_random_mix(input int count);
      int start;
      start = pending_accesses.size();
      while (pending_accesses.size() - start < count) begin
         if ($urandom_range(99) < 20) begin
            queue_lock_attempt(1'b0);
         end else begin
            queue_random_access();
         end
      end
   endtask

   task automatic wait_drained();
      do begin
         @(negedge clock);
      end while (pending_accesses.size() != 0 || req_valid || predicted_words.size() != 0);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 18;
      recv_idle_pct = 55;

      queue_access(OP_WRITE, REG_MODE, 32'hFFFF_FFFF, 16'h0000);
      queue_access(OP_READ, REG_MODE, 32'h0000_0000, 16'hFFFF);
      queue_access(OP_WRITE, REG_OTYPE, 32'hFFFF_FFFF, 16'h0000);
      queue_access(OP_READ, REG_OTYPE, 32'hFFFF_FFFF, 16'h0000);
      queue_access(OP_WRITE, REG_SPEED, 32'hA5A5_A5A5, 16'h0000);
      queue_access(OP_WRITE, REG_PULL, 32'h5A5A_5A5A, 16'h0000);
      queue_access(OP_READ, REG_PULL, 32'h0000_0000, 16'h0000);
      queue_access(OP_WRITE, REG_AF_LOW, 32'hFFFF_FFFF, 16'h0000);
      queue_access(OP_WRITE, REG_AF_HIGH, 32'h1234_5678, 16'h0000);
      queue_access(OP_READ, REG_AF_HIGH, 32'h0000_0000, 16'h0000);
      queue_access(OP_READ, REG_IDR, 32'h0000_0000, 16'hFFFF);
      queue_access(OP_READ, REG_IDR, 32'hFFFF_FFFF, 16'h0000);
      queue_access(OP_WRITE, REG_IDR, 32'hFFFF_FFFF, 16'hFFFF);
      queue_access(OP_WRITE, REG_ODR, 32'hFFFF_FFFF, 16'h0000);
      // Pins 0 to 7 are named for both set and clear; set must win there.
      queue_access(OP_WRITE, REG_BSRR, 32'hFFFF_00FF, 16'h0000);
      queue_access(OP_READ, REG_BSRR, 32'hFFFF_FFFF, 16'h0000);
      queue_access(OP_READ, REG_ODR, 32'h0000_0000, 16'h0000);
      queue_access(OP_WRITE, REG_UNMAPPED_HIGH, 32'hFFFF_FFFF, 16'hFFFF);
      queue_access(OP_READ, REG_UNMAPPED_HIGH, 32'h0000_0000, 16'hFFFF);
      queue_access(OP_READ, REG_UNMAPPED_LOW, 32'hFFFF_FFFF, 16'hFFFF);
      queue_access(OP_READ, REG_LOCK, 32'hFFFF_FFFF, 16'h0000);
      queue_access(OP_WRITE, REG_MODE, 32'h0000_0000, 16'h0000);
      queue_access(OP_READ, REG_SPEED, 32'h0000_0000, 16'h0000);
      queue_access(OP_READ, REG_AF_LOW, 32'h0000_0000, 16'h0000);
      queue_random_mix(400);
      wait_drained();

      send_idle_pct = 55;
      recv_idle_pct = 18;
      queue_random_mix(420);
      wait_drained();

      // The receiver holds off while the sender keeps offering words, then the
      // port is locked and the rest of the run writes to a locked port.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random_mix(120);
      hold_kick = ~hold_kick;
      queue_lock_attempt(1'b1);
      queue_random_mix(280);
      wait_drained();

      repeat (5) @(negedge clock);
      if (check_failures == 0) begin
         $display("[gpio_port_with_lock] OK");
      end else begin
         $display("[gpio_port_with_lock] ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("[gpio_port_with_lock] ERROR");
      $finish;
   end

endmodule
